### sv/dsd_context_range_encoder_defines.svh
// assertion macros for the dsd context range encoder
// depends on clk and rst_n being visible in the including module
`ifndef DSD_CONTEXT_RANGE_ENCODER_DEFINES_SVH
`define DSD_CONTEXT_RANGE_ENCODER_DEFINES_SVH

// property that must hold in the same cycle
`define DSDCRE_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// property that must hold in the next cycle
`define DSDCRE_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/dsdcre_pkg.sv
// shared constants, types and the probability adaptation function
// no dependencies
`default_nettype none
package dsdcre_pkg;

  localparam int CONTEXT_BITS = 10;
  localparam int ADDR_W       = CONTEXT_BITS + 1;
  localparam int DEPTH        = 2 ** ADDR_W;
  localparam int PROB_W       = 25;
  localparam int HIST_W       = 24;
  localparam int ADAPT_SHIFT  = 8;
  localparam int MAX_RESULTS  = 24;
  localparam int CNT_W        = 5;

  localparam logic [PROB_W-1:0] PROB_INIT = 25'h0800000;
  localparam logic [PROB_W-1:0] PROB_UP   = 25'h10000fe;
  localparam logic [PROB_W-1:0] PROB_DOWN = 25'h0010000;

  // request codes
  localparam logic REQ_DATA  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // register index of stereo_mode (paddr bit 2)
  localparam logic CFG_IDX_STEREO = 1'b0;

  // access to the probability memory
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [PROB_W-1:0] wr_data;
  } prob_req_t;

  // move an entry 1/256 of the way to its target, floor rounding
  function automatic logic [PROB_W-1:0] adapt(input logic [PROB_W-1:0] entry,
                                              input logic bit_val);
    logic signed [PROB_W:0] diff;
    logic signed [PROB_W:0] step;
    logic        [PROB_W:0] sum;
    diff = signed'({1'b0, (bit_val ? PROB_UP : PROB_DOWN)}) - signed'({1'b0, entry});
    step = diff >>> ADAPT_SHIFT;
    sum  = {1'b0, entry} + unsigned'(step);
    return sum[PROB_W-1:0];
  endfunction

endpackage
`default_nettype wire

### sv/dsdcre_prob_ram.sv
// probability memory: both channel tables, one read and one write port
// sweeps every entry to one half after reset; uses dsdcre_pkg
`default_nettype none
module dsdcre_prob_ram (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire dsdcre_pkg::prob_req_t       req,
  output logic [dsdcre_pkg::PROB_W-1:0]    rd_data,
  output logic                             clr_busy
);

  logic [dsdcre_pkg::PROB_W-1:0] mem [dsdcre_pkg::DEPTH];
  logic [dsdcre_pkg::PROB_W-1:0] rd_data_r;
  logic [dsdcre_pkg::ADDR_W-1:0] clr_addr_r;
  logic                          clr_busy_r;

  // clearing sweep control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + {{(dsdcre_pkg::ADDR_W-1){1'b0}}, 1'b1};
      if (&clr_addr_r) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= dsdcre_pkg::PROB_INIT;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule
`default_nettype wire

### sv/dsd_context_range_encoder.sv
// a data word codes its eight bits one after another, each through S_RD, S_MUL,
// S_UPD and S_NORM (a read-modify-write of the probability memory), emitting code
// bytes in S_NORM and waiting there while the result channel stalls; a flush word
// goes through S_NORM and S_FIN only; one word is in flight at a time
// reset: synchronous; afterwards a sweep clears all 2048 table entries to one half,
// during which in_stall stays high (register writes are still taken)
`default_nettype none
`include "dsd_context_range_encoder_defines.svh"
module dsd_context_range_encoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [7:0]  in_data_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_code_byte,
  output logic             out_last_of_run,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM,
    S_RD,
    S_MUL,
    S_UPD,
    S_FIN
  } state_t;

  localparam int CB = dsdcre_pkg::CONTEXT_BITS;
  localparam int HW = dsdcre_pkg::HIST_W;
  localparam int PW = dsdcre_pkg::PROB_W;
  localparam int NW = dsdcre_pkg::CNT_W;

  state_t            state_r, state_nxt;
  logic [31:0]       high_r, high_nxt;
  logic [31:0]       low_r, low_nxt;
  logic [HW-1:0]     hist_r [2];
  logic [HW-1:0]     hist_nxt [2];
  logic [HW-1:0]     delta_r, delta_nxt;
  logic              ch_r, ch_nxt;
  logic              stereo_r, stereo_nxt;
  logic [2:0]        k_r, k_nxt;
  logic              started_r, started_nxt;
  logic              flush_r, flush_nxt;
  logic [NW-1:0]     cnt_r, cnt_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [7:0]        pend_byte_r, pend_byte_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic [31:0]       r_r, r_nxt;
  logic [31:0]       split_r, split_nxt;

  dsdcre_pkg::prob_req_t pr;
  logic [PW-1:0]     rd_data;
  logic              clr_busy;

  logic              out_free;
  logic              in_acc;
  logic              cfg_wr;
  logic              bit_val;
  logic [3:0]        shamt;
  logic [HW-1:0]     delta_sh;
  logic [CB-1:0]     idx;
  logic [HW-1:0]     new_hist;
  logic [8:0]        p;
  logic [23:0]       mul_a;
  logic [32:0]       prod;
  logic              top_eq;
  logic              kept;

  dsdcre_prob_ram u_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (pr),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

  // handshake and register port
  assign in_stall  = (state_r != S_IDLE) || clr_busy;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign prdata    = (paddr[2] == dsdcre_pkg::CFG_IDX_STEREO) ? {31'b0, stereo_r} : 32'b0;

  // context index and current bit from the transition word
  assign bit_val  = delta_r[3'd7 - k_r];
  assign shamt    = 4'd8 - {1'b0, k_r};
  assign delta_sh = delta_r >> shamt;
  assign idx      = delta_sh[CB-1:0];
  assign new_hist = {hist_r[ch_r][HW-9:0], in_data_byte};

  // split of the range, 24 x 9 multiply
  assign p     = rd_data[24:16];
  assign mul_a = (r_r[31:24] != 8'd0) ? r_r[31:8] : r_r[23:0];
  assign prod  = mul_a * p;

  // normalisation test and result limit
  assign top_eq = (high_r[31:24] == low_r[31:24]);
  assign kept   = (cnt_r < NW'(dsdcre_pkg::MAX_RESULTS));

  // memory access
  always_comb begin
    pr         = '0;
    pr.rd_en   = (state_r == S_RD);
    pr.rd_addr = {ch_r, idx};
    pr.wr_en   = (state_r == S_MUL);
    pr.wr_addr = {ch_r, idx};
    pr.wr_data = dsdcre_pkg::adapt(rd_data, bit_val);
  end

  // next-state logic
  always_comb begin
    state_nxt      = state_r;
    high_nxt       = high_r;
    low_nxt        = low_r;
    hist_nxt[0]    = hist_r[0];
    hist_nxt[1]    = hist_r[1];
    delta_nxt      = delta_r;
    ch_nxt         = ch_r;
    stereo_nxt     = stereo_r;
    k_nxt          = k_r;
    started_nxt    = started_r;
    flush_nxt      = flush_r;
    cnt_nxt        = cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_byte_nxt  = pend_byte_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    r_nxt          = r_r;
    split_nxt      = split_r;

    if (cfg_wr && (paddr[2] == dsdcre_pkg::CFG_IDX_STEREO)) begin
      stereo_nxt = pwdata[0];
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cnt_nxt   = '0;
          state_nxt = S_NORM;
          if (in_req_type == dsdcre_pkg::REQ_FLUSH) begin
            flush_nxt = 1'b1;
            high_nxt  = low_r;
          end else begin
            flush_nxt        = 1'b0;
            started_nxt      = 1'b0;
            hist_nxt[ch_r]   = new_hist;
            delta_nxt        = new_hist ^ (new_hist >> 1);
            low_nxt          = low_r + 32'd1;
          end
        end
      end
      // emit shared top bytes, one per cycle unless the result channel stalls
      S_NORM: begin
        if (top_eq) begin
          if (!(kept && pend_valid_r && !out_free)) begin
            if (kept) begin
              if (pend_valid_r) begin
                out_valid_nxt = 1'b1;
                out_byte_nxt  = pend_byte_r;
                out_last_nxt  = 1'b0;
              end
              pend_valid_nxt = 1'b1;
              pend_byte_nxt  = high_r[31:24];
              cnt_nxt        = cnt_r + NW'(1);
            end
            high_nxt = {high_r[23:0], 8'hff};
            low_nxt  = {low_r[23:0], 8'h00};
          end
        end else if (flush_r) begin
          state_nxt = S_FIN;
        end else if (!started_r) begin
          started_nxt = 1'b1;
          k_nxt       = 3'd0;
          state_nxt   = S_RD;
        end else if (k_r == 3'd7) begin
          ch_nxt    = ch_r ^ stereo_r;
          state_nxt = S_FIN;
        end else begin
          k_nxt     = k_r + 3'd1;
          state_nxt = S_RD;
        end
      end
      // read issued, latch the range width
      S_RD: begin
        r_nxt     = high_r - low_r;
        state_nxt = S_MUL;
      end
      // entry back from memory: multiply and write the adapted entry
      S_MUL: begin
        split_nxt = (r_r[31:24] != 8'd0) ? prod[31:0] : {7'b0, prod[32:8]};
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (bit_val) begin
          high_nxt = low_r + split_r;
        end else begin
          low_nxt = low_r + 32'd1 + split_r;
        end
        state_nxt = S_NORM;
      end
      // release the held byte with its end mark
      S_FIN: begin
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = pend_byte_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      high_r       <= 32'hffffffff;
      low_r        <= 32'h0;
      hist_r[0]    <= '0;
      hist_r[1]    <= '0;
      ch_r         <= 1'b0;
      stereo_r     <= 1'b0;
      k_r          <= 3'd0;
      started_r    <= 1'b0;
      flush_r      <= 1'b0;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      high_r       <= high_nxt;
      low_r        <= low_nxt;
      hist_r[0]    <= hist_nxt[0];
      hist_r[1]    <= hist_nxt[1];
      ch_r         <= ch_nxt;
      stereo_r     <= stereo_nxt;
      k_r          <= k_nxt;
      started_r    <= started_nxt;
      flush_r      <= flush_nxt;
      cnt_r        <= cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    delta_r     <= delta_nxt;
    pend_byte_r <= pend_byte_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    r_r         <= r_nxt;
    split_r     <= split_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_code_byte   = out_byte_r;
  assign out_last_of_run = out_last_r;

  // checks
  `DSDCRE_HOLDS(a_cnt_limit, 1'b1, cnt_r <= NW'(dsdcre_pkg::MAX_RESULTS), "result count over limit")
  `DSDCRE_HOLDS(a_idle_no_pend, state_r == S_IDLE, !pend_valid_r, "held byte left at idle")
  `DSDCRE_HOLDS(a_wr_in_mul, pr.wr_en, state_r == S_MUL && !clr_busy, "table write outside update")
  `DSDCRE_NEXT(a_acc_norm, in_acc, state_r == S_NORM, "accepted word did not start")

endmodule
`default_nettype wire

### tb/sv/tb.sv
// self-checking testbench for the dsd context range encoder
// holds its own bit-exact model of the coder; depends on dsdcre_pkg and the rtl only
module tb;
  import dsdcre_pkg::*;

  localparam int CTX_SIZE      = 1 << CONTEXT_BITS;
  localparam int CTX_MASK      = CTX_SIZE - 1;
  localparam int UP_TARGET     = int'(PROB_UP);
  localparam int DOWN_TARGET   = int'(PROB_DOWN);
  localparam int INIT_PROB     = int'(PROB_INIT);
  localparam int SETTLE_CYCLES = 100;
  localparam int DRAIN_LIMIT   = 40000;
  localparam int HOLD_CYCLES   = 600;
  localparam int MAX_REPORTS   = 10;

  localparam logic [2:0] ADDR_STEREO = {CFG_IDX_STEREO, 2'b00};
  localparam logic [2:0] ADDR_SPARE  = 3'd4;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } code_word_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // block ports
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = REQ_DATA;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_code_byte;
  logic        out_last_of_run;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  dsd_context_range_encoder u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_byte   (out_code_byte),
    .out_last_of_run (out_last_of_run),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // coder model state
  int          ctx_prob [2][CTX_SIZE];
  logic [23:0] hist [2];
  bit   [31:0] rng_hi;
  bit   [31:0] rng_lo;
  bit          chan;
  bit          stereo_on;

  logic [7:0] pend_bytes [$];
  code_word_t code_q [$];

  // run control and bookkeeping
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int fault_count = 0;
  int n_words = 0;
  int n_flushes = 0;
  int n_codes = 0;
  logic [7:0] prev_byte = 8'h00;

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  function automatic void clear_model();
    for (int c = 0; c < 2; c++) begin
      for (int i = 0; i < CTX_SIZE; i++) ctx_prob[c][i] = INIT_PROB;
      hist[c] = '0;
    end
    rng_hi = 32'hffff_ffff;
    rng_lo = 32'h0;
    chan = 1'b0;
    stereo_on = 1'b0;
  endfunction

  // emit the top byte while high and low agree on it, keeping at most MAX_RESULTS
  function automatic void shed_top_bytes();
    while (rng_hi[31:24] == rng_lo[31:24]) begin
      if (pend_bytes.size() < MAX_RESULTS) pend_bytes.push_back(rng_hi[31:24]);
      rng_hi = {rng_hi[23:0], 8'hff};
      rng_lo = {rng_lo[23:0], 8'h00};
    end
  endfunction

  // code one accepted word and queue the bytes it yields
  function automatic void predict_codes(input logic rt, input logic [7:0] db);
    logic [23:0] trans;
    bit   [31:0] span;
    bit   [31:0] prod;
    bit   [31:0] split;
    bit   [31:0] p;
    int          idx;
    int          ent;
    int          ch;
    code_word_t  cw;
    pend_bytes.delete();
    if (rt == REQ_FLUSH) begin
      rng_hi = rng_lo;
      shed_top_bytes();
    end else begin
      ch = int'(chan);
      hist[ch] = {hist[ch][15:0], db};
      trans = (hist[ch] >> 1) ^ hist[ch];
      rng_lo = rng_lo + 32'd1;
      shed_top_bytes();
      for (int k = 0; k < 8; k++) begin
        idx = int'((trans >> (8 - k)) & CTX_MASK);
        ent = ctx_prob[ch][idx];
        p = 32'((ent >> 16) & 32'h1ff);
        span = rng_hi - rng_lo;
        if (span[31:24] != 8'h00) begin
          split = (span >> 8) * p;
        end else begin
          prod = span * p;
          split = prod >> 8;
        end
        // a one narrows from above, a zero from below; entry drifts toward its target
        if (trans[7 - k]) begin
          rng_hi = rng_lo + split;
          ent = ent + ((UP_TARGET - ent) >>> 8);
        end else begin
          rng_lo = rng_lo + 32'd1 + split;
          ent = ent + ((DOWN_TARGET - ent) >>> 8);
        end
        ctx_prob[ch][idx] = ent;
        shed_top_bytes();
      end
      chan = chan ^ stereo_on;
    end
    foreach (pend_bytes[i]) begin
      cw.code = pend_bytes[i];
      cw.last = (i == pend_bytes.size() - 1);
      code_q.push_back(cw);
    end
  endfunction

  // receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // compare each accepted code word with the oldest prediction
  always @(posedge clk) begin : check_codes
    code_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (code_q.size() == 0) begin
        note_fault($sformatf("unexpected code byte %02h last %0b",
                             out_code_byte, out_last_of_run));
      end else begin
        want = code_q.pop_front();
        n_codes++;
        if (out_code_byte !== want.code || out_last_of_run !== want.last)
          note_fault($sformatf("code byte exp %02h last %0b, got %02h last %0b",
                               want.code, want.last, out_code_byte, out_last_of_run));
      end
    end
  end

  // offer one word after a random gap and wait until it is taken
  task automatic send_word(input logic rt, input logic [7:0] db);
    int gap;
    gap = 0;
    while (gap < 200 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_data_byte <= db;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_codes(rt, db);
    n_words++;
    if (rt == REQ_FLUSH) n_flushes++;
  endtask

  // stop offering and wait for every predicted byte, then let the block settle
  task automatic wait_drained();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (code_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write a register, then read stereo_mode back
  task automatic program_reg(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] rd;
    in_valid <= 1'b0;
    apb_access(1'b1, addr, value, rd);
    if (addr == ADDR_STEREO) stereo_on = value[0];
    apb_access(1'b0, ADDR_STEREO, 32'd0, rd);
    if (rd !== {31'd0, stereo_on})
      note_fault($sformatf("stereo_mode read exp %0d, got %08h", stereo_on, rd));
  endtask

  // dsd-like byte source: noise, silence, repeats and idle-tone patterns
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(4))
      0: b = $urandom_range(1) ? 8'h00 : 8'hff;
      1: b = prev_byte;
      2: b = $urandom_range(1) ? 8'h69 : 8'h96;
      3: b = $urandom_range(1) ? 8'h55 : 8'haa;
      default: b = 8'($urandom_range(255));
    endcase
    prev_byte = b;
    return b;
  endfunction

  // field extremes, flushes back to back, flush with a non-zero byte
  task automatic test_extremes();
    idle_pct = 0;
    stall_pct = 0;
    send_word(REQ_DATA, 8'h00);
    send_word(REQ_DATA, 8'hff);
    send_word(REQ_DATA, 8'h01);
    send_word(REQ_DATA, 8'h80);
    send_word(REQ_DATA, 8'h55);
    send_word(REQ_DATA, 8'haa);
    send_word(REQ_DATA, 8'h7f);
    send_word(REQ_DATA, 8'hfe);
    send_word(REQ_FLUSH, 8'h00);
    send_word(REQ_FLUSH, 8'h00);
    send_word(REQ_FLUSH, 8'hff);
    wait_drained();
  endtask

  // channel interleave, spare address, stereo dropped while on channel one
  task automatic test_stereo();
    program_reg(ADDR_STEREO, 32'hffff_ffff);
    send_word(REQ_DATA, 8'h00);
    send_word(REQ_DATA, 8'hff);
    send_word(REQ_DATA, 8'h69);
    wait_drained();
    program_reg(ADDR_SPARE, 32'h0);
    send_word(REQ_DATA, 8'h96);
    send_word(REQ_DATA, 8'h00);
    send_word(REQ_DATA, 8'h00);
    send_word(REQ_DATA, 8'h69);
    wait_drained();
    program_reg(ADDR_STEREO, 32'h0);
    send_word(REQ_DATA, 8'h00);
    send_word(REQ_DATA, 8'haa);
    send_word(REQ_DATA, 8'h55);
    send_word(REQ_FLUSH, 8'h00);
    wait_drained();
  endtask

  // random words under one idling setting and one stereo setting
  task automatic test_random(input int n, input int idle, input int stall, input bit st);
    program_reg(ADDR_STEREO, {31'd0, st});
    idle_pct = idle;
    stall_pct = stall;
    repeat (n) begin
      if ($urandom_range(19) == 0) send_word(REQ_FLUSH, 8'($urandom_range(255)));
      else send_word(REQ_DATA, pick_byte());
    end
    wait_drained();
  endtask

  // long receiver hold-off while words keep coming, so the input stalls
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_requests++;
    repeat (11) send_word(REQ_DATA, pick_byte());
    send_word(REQ_FLUSH, 8'h00);
    wait_drained();
  endtask

  initial begin
    clear_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_stereo();
    test_random(60, 0, 0, 1'b0);
    test_random(60, 88, 0, 1'b1);
    test_random(60, 0, 88, 1'b0);
    test_random(60, 16, 16, 1'b1);
    test_backpressure();
    if (code_q.size() != 0)
      note_fault($sformatf("%0d code bytes never arrived", code_q.size()));
    $display("covered %0d words (%0d flushes) and %0d code bytes, mono and stereo,",
             n_words, n_flushes, n_codes);
    $display("with sender gaps, receiver stalls and a long hold-off");
    if (fault_count == 0) begin
      $display("[dsd_context_range_encoder] OK");
    end else begin
      $display("[dsd_context_range_encoder] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout");
    $display("[dsd_context_range_encoder] ERROR");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/dsdcre_pkg.sv
sv/dsdcre_prob_ram.sv
sv/dsd_context_range_encoder.sv
tb/sv/tb.sv
